// ----- rtl/core/rse_pkg.sv -----
// ----------------------------------------------------------------------------
// rse_pkg
// Shared constants and the GF(2^8) multiplier of the systematic
// Reed-Solomon check-symbol encoder.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int unsigned MaxChecksDefault = 8;

  localparam int unsigned SymW     = 8;
  localparam int unsigned CoeffW   = 64;
  localparam int unsigned CountW   = 4;
  localparam int unsigned PosOutW  = 3;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CFG_FIELD_POLY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GEN_COEFFS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CHECK_CNT  = 2'd2;

  localparam logic [SymW-1:0]   FieldPolyReset  = 8'h1d;
  localparam logic [CoeffW-1:0] GenCoeffsReset  = 64'h0;
  localparam logic [CountW-1:0] CheckCountReset = 4'd4;

  // Shift-and-reduce product modulo x^8 + poly.
  function automatic logic [SymW-1:0] gf_mul(input logic [SymW-1:0] a,
                                             input logic [SymW-1:0] b,
                                             input logic [SymW-1:0] poly);
    logic [SymW-1:0] acc;
    logic [SymW-1:0] x;
    acc = '0;
    x   = a;
    for (int bit_idx = 0; bit_idx < SymW; bit_idx++) begin
      if (b[bit_idx]) begin
        acc = acc ^ x;
      end
      if (x[SymW-1]) begin
        x = {x[SymW-2:0], 1'b0} ^ poly;
      end else begin
        x = {x[SymW-2:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage

// ----- rtl/core/reed_solomon_systematic_encoder.sv -----
// ----------------------------------------------------------------------------
// reed_solomon_systematic_encoder
// Systematic Reed-Solomon check-symbol encoder over GF(2^8).
// ----------------------------------------------------------------------------
// Data symbols arrive on the input channel, one request per symbol, with
// last_data marking the final symbol of a codeword. Each symbol is folded
// into the remainder register in the cycle it is accepted, so the input
// takes one symbol per cycle. After the final symbol, the K check symbols
// leave on the output channel one per cycle, highest order first. They start
// in the cycle after that symbol was accepted if no earlier codeword is still
// leaving; last_check marks the final one. The remainder is cleared at once,
// so the next codeword may follow in the next cycle. A second finished
// remainder is held in a pending bank while the first is unloaded. While the
// pending bank is full, the input stalls for every symbol until the first
// codeword has fully left. A receiver stall holds the current check symbol.
// Reset clears the remainder and both banks and loads the default
// configuration (polynomial 0x1d, zero coefficients, four check symbols).
// Configuration writes take effect at the next edge and must be made idle.
// ----------------------------------------------------------------------------
module reed_solomon_systematic_encoder #(
  parameter int unsigned MaxChecks = rse_pkg::MaxChecksDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rse_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [rse_pkg::CoeffW-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rse_pkg::SymW-1:0]            data_symbol_i,
  input  logic                                last_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rse_pkg::SymW-1:0]            check_symbol_o,
  output logic [rse_pkg::PosOutW-1:0]         check_position_o,
  output logic                                last_check_o
);

  localparam int unsigned PosW = (MaxChecks > 1) ? $clog2(MaxChecks) : 1;

  logic [rse_pkg::SymW-1:0]                field_poly_q;
  logic [rse_pkg::CoeffW-1:0]              gen_coeffs_q;
  logic [rse_pkg::CountW-1:0]              check_count_q;
  logic [PosW-1:0]                         last_idx;
  logic                                    in_fire;
  logic                                    snap_valid;
  logic [MaxChecks-1:0][rse_pkg::SymW-1:0] snap_data;
  logic [PosW-1:0]                         snap_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_poly_q  <= rse_pkg::FieldPolyReset;
      gen_coeffs_q  <= rse_pkg::GenCoeffsReset;
      check_count_q <= rse_pkg::CheckCountReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rse_pkg::CFG_FIELD_POLY: field_poly_q  <= cfg_wdata_i[rse_pkg::SymW-1:0];
        rse_pkg::CFG_GEN_COEFFS: gen_coeffs_q  <= cfg_wdata_i;
        rse_pkg::CFG_CHECK_CNT:  check_count_q <= cfg_wdata_i[rse_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (check_count_q == '0) begin
      last_idx = '0;
    end else if (check_count_q > rse_pkg::CountW'(MaxChecks)) begin
      last_idx = PosW'(MaxChecks - 1);
    end else begin
      last_idx = PosW'(check_count_q - rse_pkg::CountW'(1));
    end
  end

  assign in_fire = in_valid_i & in_ready_o;

  rse_lfsr #(
    .MaxChecks (MaxChecks),
    .PosW      (PosW)
  ) u_lfsr (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_fire),
    .data_symbol_i (data_symbol_i),
    .last_data_i   (last_data_i),
    .field_poly_i  (field_poly_q),
    .gen_coeffs_i  (gen_coeffs_q),
    .last_idx_i    (last_idx),
    .snap_valid_o  (snap_valid),
    .snap_data_o   (snap_data),
    .snap_last_o   (snap_last)
  );

  rse_emit #(
    .MaxChecks (MaxChecks),
    .PosW      (PosW)
  ) u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .snap_valid_i     (snap_valid),
    .snap_data_i      (snap_data),
    .snap_last_i      (snap_last),
    .snap_ready_o     (in_ready_o),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .check_symbol_o   (check_symbol_o),
    .check_position_o (check_position_o),
    .last_check_o     (last_check_o)
  );

endmodule

// ----- rtl/core/rse_lfsr.sv -----
// ----------------------------------------------------------------------------
// rse_lfsr
// Remainder shift register: one division step per accepted data symbol,
// and a snapshot of the remainder on the final symbol of a codeword.
// ----------------------------------------------------------------------------
module rse_lfsr #(
  parameter int unsigned MaxChecks = rse_pkg::MaxChecksDefault,
  parameter int unsigned PosW      = (MaxChecks > 1) ? $clog2(MaxChecks) : 1
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    accept_i,
  input  logic [rse_pkg::SymW-1:0]                data_symbol_i,
  input  logic                                    last_data_i,
  input  logic [rse_pkg::SymW-1:0]                field_poly_i,
  input  logic [rse_pkg::CoeffW-1:0]              gen_coeffs_i,
  input  logic [PosW-1:0]                         last_idx_i,
  output logic                                    snap_valid_o,
  output logic [MaxChecks-1:0][rse_pkg::SymW-1:0] snap_data_o,
  output logic [PosW-1:0]                         snap_last_o
);

  logic [MaxChecks-1:0][rse_pkg::SymW-1:0] rem_q, rem_d, rem_step;
  logic [MaxChecks:0][rse_pkg::SymW-1:0]   rem_ext;
  logic [rse_pkg::SymW-1:0]                fb;

  always_comb begin
    rem_ext            = '0;
    rem_ext[MaxChecks-1:0] = rem_q;
    fb = rem_q[0] ^ data_symbol_i;
    for (int i = 0; i < MaxChecks; i++) begin
      if (PosW'(i) < last_idx_i) begin
        rem_step[i] = rem_ext[i+1] ^
                      rse_pkg::gf_mul(fb, gen_coeffs_i[8*i +: 8], field_poly_i);
      end else if (PosW'(i) == last_idx_i) begin
        rem_step[i] = rse_pkg::gf_mul(fb, gen_coeffs_i[8*i +: 8], field_poly_i);
      end else begin
        rem_step[i] = rem_q[i];
      end
    end
    rem_d = rem_q;
    if (accept_i) begin
      rem_d = last_data_i ? '0 : rem_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  assign snap_valid_o = accept_i & last_data_i;
  assign snap_data_o  = rem_step;
  assign snap_last_o  = last_idx_i;

endmodule

// ----- rtl/core/rse_emit.sv -----
// ----------------------------------------------------------------------------
// rse_emit
// Check-symbol unloader: an active bank that hands out one check symbol
// per request and a pending bank that holds the next codeword's remainder.
// ----------------------------------------------------------------------------
module rse_emit #(
  parameter int unsigned MaxChecks = rse_pkg::MaxChecksDefault,
  parameter int unsigned PosW      = (MaxChecks > 1) ? $clog2(MaxChecks) : 1
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    snap_valid_i,
  input  logic [MaxChecks-1:0][rse_pkg::SymW-1:0] snap_data_i,
  input  logic [PosW-1:0]                         snap_last_i,
  output logic                                    snap_ready_o,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [rse_pkg::SymW-1:0]                check_symbol_o,
  output logic [rse_pkg::PosOutW-1:0]             check_position_o,
  output logic                                    last_check_o
);

  logic                                    act_valid_q, act_valid_d;
  logic [MaxChecks-1:0][rse_pkg::SymW-1:0] act_data_q, act_data_d;
  logic [PosW-1:0]                         act_pos_q, act_pos_d;
  logic [PosW-1:0]                         act_last_q, act_last_d;
  logic                                    pend_valid_q, pend_valid_d;
  logic [MaxChecks-1:0][rse_pkg::SymW-1:0] pend_data_q, pend_data_d;
  logic [PosW-1:0]                         pend_last_q, pend_last_d;
  logic                                    out_fire, act_done;

  assign out_fire = act_valid_q & out_ready_i;
  assign act_done = out_fire & (act_pos_q == act_last_q);

  always_comb begin
    act_valid_d  = act_valid_q;
    act_data_d   = act_data_q;
    act_pos_d    = act_pos_q;
    act_last_d   = act_last_q;
    pend_valid_d = pend_valid_q;
    pend_data_d  = pend_data_q;
    pend_last_d  = pend_last_q;
    if (out_fire && !act_done) begin
      act_pos_d = act_pos_q + PosW'(1);
    end
    if (act_done || !act_valid_q) begin
      if (pend_valid_q) begin
        act_valid_d  = 1'b1;
        act_data_d   = pend_data_q;
        act_last_d   = pend_last_q;
        act_pos_d    = '0;
        pend_valid_d = 1'b0;
      end else if (snap_valid_i) begin
        act_valid_d = 1'b1;
        act_data_d  = snap_data_i;
        act_last_d  = snap_last_i;
        act_pos_d   = '0;
      end else begin
        act_valid_d = 1'b0;
      end
    end else if (snap_valid_i) begin
      pend_valid_d = 1'b1;
      pend_data_d  = snap_data_i;
      pend_last_d  = snap_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_valid_q  <= 1'b0;
      act_pos_q    <= '0;
      act_last_q   <= '0;
      pend_valid_q <= 1'b0;
      pend_last_q  <= '0;
    end else begin
      act_valid_q  <= act_valid_d;
      act_pos_q    <= act_pos_d;
      act_last_q   <= act_last_d;
      pend_valid_q <= pend_valid_d;
      pend_last_q  <= pend_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_data_q  <= act_data_d;
    pend_data_q <= pend_data_d;
  end

  assign snap_ready_o     = ~pend_valid_q;
  assign out_valid_o      = act_valid_q;
  assign check_symbol_o   = act_data_q[act_pos_q];
  assign check_position_o = rse_pkg::PosOutW'(act_pos_q);
  assign last_check_o     = (act_pos_q == act_last_q);

  a_pend_needs_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> act_valid_q)
    else $error("pending remainder held with no active remainder");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_valid_q |-> (act_pos_q <= act_last_q))
    else $error("check position beyond the final check symbol");

  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !act_done) |=> (act_pos_q == $past(act_pos_q) + PosW'(1)))
    else $error("check position did not advance after a request");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_i |-> !pend_valid_q)
    else $error("remainder arrived while both banks were full");

endmodule

// ----- sim/reed_solomon_systematic_encoder_test.sv -----
// ----------------------------------------------------------------------------
// reed_solomon_systematic_encoder_test
// Self-checking testbench for the systematic Reed-Solomon check-symbol encoder.
// ----------------------------------------------------------------------------
// Data symbols are sent one request at a time. A behavioural copy of the
// remainder register folds in every accepted symbol and queues the check
// symbols that a finished codeword must produce. A checker compares each
// check symbol that leaves the block with the oldest queued one. Directed
// tests cover the default set-up, single parity, field and count extremes,
// and a change of check count part-way through a codeword. Random codewords
// then run in three phases of sender and receiver stalls, the last with none.
// ----------------------------------------------------------------------------
module reed_solomon_systematic_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumChecks   = rse_pkg::MaxChecksDefault;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TailCycles  = 2 * NumChecks + 4;
  localparam int unsigned PhaseItems  = 120;
  localparam int unsigned ReportLimit = 100;

  typedef struct packed {
    logic [rse_pkg::SymW-1:0]    symbol;
    logic [rse_pkg::PosOutW-1:0] position;
    logic                        last;
  } check_t;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        cfg_we_i      = 1'b0;
  logic [rse_pkg::CfgIdxW-1:0] cfg_index_i   = '0;
  logic [rse_pkg::CoeffW-1:0]  cfg_wdata_i   = '0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_ready_o;
  logic [rse_pkg::SymW-1:0]    data_symbol_i = '0;
  logic                        last_data_i   = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i   = 1'b0;
  logic [rse_pkg::SymW-1:0]    check_symbol_o;
  logic [rse_pkg::PosOutW-1:0] check_position_o;
  logic                        last_check_o;

  logic [rse_pkg::SymW-1:0]   poly_cfg   = rse_pkg::FieldPolyReset;
  logic [rse_pkg::CoeffW-1:0] coeffs_cfg = rse_pkg::GenCoeffsReset;
  logic [rse_pkg::CountW-1:0] count_cfg  = rse_pkg::CheckCountReset;
  logic [rse_pkg::SymW-1:0]   remainder [NumChecks] = '{default: '0};
  check_t                     pending_checks [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;

  reed_solomon_systematic_encoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_symbol_i    (data_symbol_i),
    .last_data_i      (last_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .check_symbol_o   (check_symbol_o),
    .check_position_o (check_position_o),
    .last_check_o     (last_check_o)
  );

  always #4 clk_i = ~clk_i;

  // Horner evaluation: multiply by x and reduce, then add the next term.
  function automatic logic [rse_pkg::SymW-1:0] gf_product(
    input logic [rse_pkg::SymW-1:0] a,
    input logic [rse_pkg::SymW-1:0] b);
    logic [rse_pkg::SymW-1:0] acc;
    acc = '0;
    for (int i = rse_pkg::SymW - 1; i >= 0; i--) begin
      acc = {acc[rse_pkg::SymW-2:0], 1'b0} ^ ({rse_pkg::SymW{acc[rse_pkg::SymW-1]}} & poly_cfg);
      if (b[i]) begin
        acc = acc ^ a;
      end
    end
    return acc;
  endfunction

  function automatic void fold_symbol(input logic [rse_pkg::SymW-1:0] sym, input logic last);
    int unsigned              k;
    logic [rse_pkg::SymW-1:0] feedback;
    check_t                   chk;
    if (count_cfg == 0) begin
      k = 1;
    end else if (count_cfg > NumChecks) begin
      k = NumChecks;
    end else begin
      k = count_cfg;
    end
    feedback = remainder[0] ^ sym;
    for (int unsigned i = 0; i + 1 < k; i++) begin
      remainder[i] = remainder[i+1] ^
                     gf_product(feedback, coeffs_cfg[rse_pkg::SymW*i +: rse_pkg::SymW]);
    end
    remainder[k-1] = gf_product(feedback, coeffs_cfg[rse_pkg::SymW*(k-1) +: rse_pkg::SymW]);
    if (last) begin
      for (int unsigned i = 0; i < k; i++) begin
        chk.symbol   = remainder[i];
        chk.position = rse_pkg::PosOutW'(i);
        chk.last     = (i + 1 == k);
        pending_checks.push_back(chk);
      end
      foreach (remainder[i]) begin
        remainder[i] = '0;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [rse_pkg::SymW-1:0] got,
                                 input logic [rse_pkg::SymW-1:0] want);
    mismatches++;
    if (mismatches <= ReportLimit) begin
      $display("%0t ns: %s is 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  task automatic send_symbol(input logic [rse_pkg::SymW-1:0] sym, input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_symbol_i <= sym;
    last_data_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    fold_symbol(sym, last);
  endtask

  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_checks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rse_pkg::CfgIdxW-1:0] idx,
                           input logic [rse_pkg::CoeffW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      rse_pkg::CFG_FIELD_POLY: poly_cfg   = value[rse_pkg::SymW-1:0];
      rse_pkg::CFG_GEN_COEFFS: coeffs_cfg = value;
      rse_pkg::CFG_CHECK_CNT:  count_cfg  = value[rse_pkg::CountW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [rse_pkg::SymW-1:0] poly,
                           input logic [rse_pkg::CoeffW-1:0] coeffs,
                           input logic [rse_pkg::CountW-1:0] count);
    quiesce();
    write_reg(rse_pkg::CFG_FIELD_POLY, rse_pkg::CoeffW'(poly));
    write_reg(rse_pkg::CFG_GEN_COEFFS, coeffs);
    write_reg(rse_pkg::CFG_CHECK_CNT, rse_pkg::CoeffW'(count));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hff, 1'b0);
    send_symbol(8'h80, 1'b1);
  endtask

  task automatic test_single_parity();
    configure(8'h1d, 64'h1, 4'd1);
    send_symbol(8'ha5, 1'b0);
    send_symbol(8'h5a, 1'b0);
    send_symbol(8'hff, 1'b1);
    send_symbol(8'h37, 1'b1);
  endtask

  task automatic test_field_extremes();
    configure(8'hff, '1, 4'd8);
    send_symbol(8'hff, 1'b0);
    send_symbol(8'h01, 1'b1);
    configure(8'h00, 64'h0102_0408_1020_4080, 4'd15);
    send_symbol(8'h80, 1'b0);
    send_symbol(8'h80, 1'b1);
  endtask

  task automatic test_count_zero();
    configure(8'h71, {$urandom, $urandom}, 4'd0);
    send_symbol(8'h12, 1'b0);
    send_symbol(8'h34, 1'b1);
  endtask

  // The registers left above a reduced count must survive until the next
  // codeword ends, and must then be cleared with the rest.
  task automatic test_count_change_mid_codeword();
    logic [rse_pkg::CoeffW-1:0] coeffs;
    coeffs = {$urandom, $urandom};
    configure(8'h1d, coeffs, 4'd8);
    send_symbol(8'h11, 1'b0);
    send_symbol(8'h22, 1'b0);
    send_symbol(8'h33, 1'b0);
    configure(8'h1d, coeffs, 4'd3);
    send_symbol(8'h44, 1'b0);
    send_symbol(8'h55, 1'b1);
    configure(8'h1d, coeffs, 4'd8);
    send_symbol(8'h66, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned                sent;
    int unsigned                since_cfg;
    int unsigned                len;
    logic [rse_pkg::SymW-1:0]   poly;
    logic [rse_pkg::CoeffW-1:0] coeffs;
    logic [rse_pkg::CountW-1:0] count;
    logic [rse_pkg::SymW-1:0]   sym;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent          = 0;
    since_cfg     = PhaseItems;
    while (sent < PhaseItems) begin
      if (since_cfg >= 40) begin
        case ($urandom_range(4))
          0:       poly = 8'h1d;
          1:       poly = 8'h00;
          2:       poly = 8'hff;
          default: poly = rse_pkg::SymW'($urandom_range(255));
        endcase
        coeffs = ($urandom_range(7) == 0) ? '1 : {$urandom, $urandom};
        count  = ($urandom_range(5) == 0) ? rse_pkg::CountW'($urandom_range(15))
                                          : rse_pkg::CountW'($urandom_range(8, 1));
        configure(poly, coeffs, count);
        since_cfg = 0;
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(12, 1);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(7) == 0) begin
          sym = ($urandom_range(1) == 0) ? 8'h00 : 8'hff;
        end else begin
          sym = rse_pkg::SymW'($urandom_range(255));
        end
        send_symbol(sym, i + 1 == len);
      end
      sent      += len;
      since_cfg += len;
      if ($urandom_range(11) == 0) begin
        quiesce();
      end
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    check_t expected_check;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_checks.size() == 0) begin
        report_mismatch("unexpected check symbol", check_symbol_o, '0);
      end else begin
        expected_check = pending_checks.pop_front();
        if (check_symbol_o !== expected_check.symbol) begin
          report_mismatch("check_symbol", check_symbol_o, expected_check.symbol);
        end
        if (check_position_o !== expected_check.position) begin
          report_mismatch("check_position", rse_pkg::SymW'(check_position_o),
                          rse_pkg::SymW'(expected_check.position));
        end
        if (last_check_o !== expected_check.last) begin
          report_mismatch("last_check", rse_pkg::SymW'(last_check_o),
                          rse_pkg::SymW'(expected_check.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Watchdog: no request accepted for %0d cycles.", StallLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 38;
    recv_idle_pct = 64;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_single_parity();
    test_field_extremes();
    test_count_zero();
    test_count_change_mid_codeword();
    test_random_traffic(38, 64);
    test_random_traffic(64, 38);
    test_random_traffic(0, 0);

    quiesce();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
